// ----- hdl/lst3d_pkg.sv -----
// ----------------------------------------------------------------------------
// lst3d_pkg: shared types, constants and arithmetic helpers
// Holds the command codes, pose types, stack sizing and the fixed-point
// rounding and saturation helpers used by the 3D turtle datapath.
// ----------------------------------------------------------------------------
package lst3d_pkg;

  // Stack sizing.
  localparam int STACK_DEPTH = 32;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Configuration register indexes.
  localparam logic [7:0] REG_STEP_LENGTH = 8'd0;
  localparam logic [7:0] REG_COS_TURN    = 8'd1;
  localparam logic [7:0] REG_SIN_TURN    = 8'd2;
  localparam logic [7:0] REG_START_X     = 8'd3;
  localparam logic [7:0] REG_START_Y     = 8'd4;

  // Command characters.
  localparam logic [7:0] SYM_DRAW      = "F";
  localparam logic [7:0] SYM_MOVE      = "f";
  localparam logic [7:0] SYM_YAW_POS   = "+";
  localparam logic [7:0] SYM_YAW_NEG   = "-";
  localparam logic [7:0] SYM_PITCH_POS = "&";
  localparam logic [7:0] SYM_PITCH_NEG = "^";
  localparam logic [7:0] SYM_ROLL_POS  = "\\";
  localparam logic [7:0] SYM_ROLL_NEG  = "/";
  localparam logic [7:0] SYM_FLIP      = "|";
  localparam logic [7:0] SYM_PUSH      = "[";
  localparam logic [7:0] SYM_POP       = "]";

  typedef logic signed [31:0] coord_t;
  typedef logic signed [15:0] q14_t;
  typedef coord_t [2:0]       pos_t;
  typedef q14_t   [8:0]       ori_t;

  typedef struct packed {
    pos_t pos;
    ori_t ori;
  } pose_t;

  // Stack control and status between the datapath and the stack.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stk_stat_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_RESTART,
    CMD_DRAW,
    CMD_MOVE,
    CMD_YAW_POS,
    CMD_YAW_NEG,
    CMD_PITCH_POS,
    CMD_PITCH_NEG,
    CMD_ROLL_POS,
    CMD_ROLL_NEG,
    CMD_FLIP,
    CMD_PUSH,
    CMD_POP
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_e;

  localparam q14_t ONE_Q14  = 16'sd16384;
  localparam q14_t ZERO_Q14 = 16'sd0;
  localparam ori_t ORI_IDENTITY = {ONE_Q14, ZERO_Q14, ZERO_Q14,
                                   ZERO_Q14, ONE_Q14, ZERO_Q14,
                                   ZERO_Q14, ZERO_Q14, ONE_Q14};

  // Map an incoming request to a command; restart overrides the symbol.
  function automatic cmd_e decode_symbol(input logic [7:0] sym, input logic restart);
    cmd_e cmd;
    cmd = CMD_NONE;
    if (restart) begin
      cmd = CMD_RESTART;
    end else begin
      unique case (sym)
        SYM_DRAW:      cmd = CMD_DRAW;
        SYM_MOVE:      cmd = CMD_MOVE;
        SYM_YAW_POS:   cmd = CMD_YAW_POS;
        SYM_YAW_NEG:   cmd = CMD_YAW_NEG;
        SYM_PITCH_POS: cmd = CMD_PITCH_POS;
        SYM_PITCH_NEG: cmd = CMD_PITCH_NEG;
        SYM_ROLL_POS:  cmd = CMD_ROLL_POS;
        SYM_ROLL_NEG:  cmd = CMD_ROLL_NEG;
        SYM_FLIP:      cmd = CMD_FLIP;
        SYM_PUSH:      cmd = CMD_PUSH;
        SYM_POP:       cmd = CMD_POP;
        default:       cmd = CMD_NONE;
      endcase
    end
    return cmd;
  endfunction

  // Round a Q4.28 sum of products to Q2.14 (half up) and saturate.
  function automatic q14_t sat_q14(input logic signed [33:0] acc);
    logic signed [33:0] r;
    r = (acc + 34'sd8192) >>> 14;
    if (r > 34'sd32767) begin
      return 16'sh7fff;
    end else if (r < -34'sd32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  // Advance one coordinate by step length times a heading entry, saturated.
  function automatic coord_t step_coord(input coord_t pos, input logic [15:0] len,
                                        input q14_t h);
    logic signed [32:0] prod;
    logic signed [32:0] rnd;
    logic signed [33:0] sum;
    prod = $signed({1'b0, len}) * h;
    rnd  = prod + 33'sd32;
    sum  = 34'(pos) + 34'(rnd >>> 6);
    if (sum > 34'sh07fffffff) begin
      return 32'sh7fffffff;
    end else if (sum < -34'sh080000000) begin
      return 32'sh80000000;
    end
    return sum[31:0];
  endfunction

endpackage

// ----- hdl/lst3d_rotate.sv -----
// ----------------------------------------------------------------------------
// lst3d_rotate: orientation update for turn and flip commands
// Rotates the two affected columns of the orientation matrix by the
// configured angle, or negates the first two columns for a half turn.
// ----------------------------------------------------------------------------
module lst3d_rotate
  import lst3d_pkg::*;
(
  input  cmd_e cmd_i,
  input  ori_t ori_i,
  input  q14_t cos_i,
  input  q14_t sin_i,
  output ori_t ori_o
);

  // Negate with the most negative value clamped to the largest positive one.
  function automatic q14_t neg_sat(input q14_t v);
    if (v == 16'sh8000) begin
      return 16'sh7fff;
    end
    return -v;
  endfunction

  logic [1:0]         col_p;
  logic [1:0]         col_q;
  logic               turn;
  logic signed [16:0] sin_ext;
  logic signed [16:0] sin_eff;
  q14_t               a;
  q14_t               b;
  logic signed [31:0] prod_ac;
  logic signed [31:0] prod_bc;
  logic signed [32:0] prod_as;
  logic signed [32:0] prod_bs;
  logic [3:0]         idx_p;
  logic [3:0]         idx_q;

  assign sin_ext = 17'(sin_i);

  // Each turn works on one column pair: p' = a*c - b*s', q' = a*s' + b*c.
  // Pitch and roll use the opposite sign of sine from yaw.
  always_comb begin
    ori_o   = ori_i;
    col_p   = 2'd0;
    col_q   = 2'd1;
    turn    = 1'b0;
    sin_eff = sin_ext;
    a       = '0;
    b       = '0;
    prod_ac = '0;
    prod_bc = '0;
    prod_as = '0;
    prod_bs = '0;
    idx_p   = '0;
    idx_q   = '0;
    unique case (cmd_i)
      CMD_YAW_POS: begin
        col_p = 2'd0; col_q = 2'd1; sin_eff = sin_ext;  turn = 1'b1;
      end
      CMD_YAW_NEG: begin
        col_p = 2'd0; col_q = 2'd1; sin_eff = -sin_ext; turn = 1'b1;
      end
      CMD_PITCH_POS: begin
        col_p = 2'd0; col_q = 2'd2; sin_eff = -sin_ext; turn = 1'b1;
      end
      CMD_PITCH_NEG: begin
        col_p = 2'd0; col_q = 2'd2; sin_eff = sin_ext;  turn = 1'b1;
      end
      CMD_ROLL_POS: begin
        col_p = 2'd1; col_q = 2'd2; sin_eff = -sin_ext; turn = 1'b1;
      end
      CMD_ROLL_NEG: begin
        col_p = 2'd1; col_q = 2'd2; sin_eff = sin_ext;  turn = 1'b1;
      end
      CMD_FLIP: begin
        for (int r = 0; r < 3; r++) begin
          ori_o[r*3]     = neg_sat(ori_i[r*3]);
          ori_o[r*3 + 1] = neg_sat(ori_i[r*3 + 1]);
        end
      end
      default: begin
      end
    endcase

    // One planar rotation per row; rows are independent.
    if (turn) begin
      for (int r = 0; r < 3; r++) begin
        idx_p   = 4'(r * 3) + {2'b00, col_p};
        idx_q   = 4'(r * 3) + {2'b00, col_q};
        a       = ori_i[idx_p];
        b       = ori_i[idx_q];
        prod_ac = a * cos_i;
        prod_bc = b * cos_i;
        prod_as = a * sin_eff;
        prod_bs = b * sin_eff;
        ori_o[idx_p] = sat_q14(34'(prod_ac) - 34'(prod_bs));
        ori_o[idx_q] = sat_q14(34'(prod_as) + 34'(prod_bc));
      end
    end
  end

endmodule

// ----- hdl/lst3d_stack.sv -----
// ----------------------------------------------------------------------------
// lst3d_stack: bounded pose stack
// Keeps every pushed pose in a memory, holds the top entry in a register and
// prefetches the entry below it, so a pop is served from registers.
// ----------------------------------------------------------------------------
module lst3d_stack
  import lst3d_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  stk_ctrl_t ctrl_i,
  input  pose_t     pose_i,
  output pose_t     top_o,
  output stk_stat_t stat_o
);

  pose_t             mem [STACK_DEPTH];
  pose_t             top_q;
  pose_t             below_q;
  logic [LVL_W-1:0]  level_q;
  logic [LVL_W-1:0]  level_d;
  logic [LVL_W-1:0]  rd_lvl;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  // Fill level: entries in use.
  always_comb begin
    level_d = level_q;
    priority if (ctrl_i.clear) begin
      level_d = '0;
    end else if (ctrl_i.push) begin
      level_d = level_q + LVL_W'(1);
    end else if (ctrl_i.pop) begin
      level_d = level_q - LVL_W'(1);
    end else begin
      level_d = level_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else begin
      level_q <= level_d;
    end
  end

  // The entry below the next top is read ahead, one level under the top.
  assign rd_lvl  = level_d - LVL_W'(2);
  assign rd_addr = rd_lvl[ADDR_W-1:0];
  assign wr_addr = level_q[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wr_addr] <= pose_i;
    end
    below_q <= mem[rd_addr];
  end

  // Top register takes the pushed pose, or the prefetched entry below on a pop.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      top_q <= pose_i;
    end else if (ctrl_i.pop) begin
      top_q <= below_q;
    end
  end

  assign top_o        = top_q;
  assign stat_o.full  = (level_q == LVL_W'(STACK_DEPTH));
  assign stat_o.empty = (level_q == '0);

  // A push and a pop never arrive together.
  a_push_pop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.push && ctrl_i.pop))
    else $error("stack push and pop in the same cycle");

  // The datapath never pushes into a full stack or pops an empty one.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.push |-> !stat_o.full) and (ctrl_i.pop |-> !stat_o.empty))
    else $error("stack overrun or underrun reached the storage");

  // A pop lowers the level by exactly one.
  a_pop_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.pop && !ctrl_i.clear) |=> (level_q == $past(level_q) - LVL_W'(1)))
    else $error("stack level did not drop after a pop");

  // A pushed pose becomes the visible top once the top register is loaded.
  a_push_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |=> (top_o == $past(pose_i)))
    else $error("pushed pose not on top of the stack");

endmodule

// ----- hdl/lsystem_turtle_3d.sv -----
// ----------------------------------------------------------------------------
// lsystem_turtle_3d: 3D turtle interpreter for an L-system symbol stream
// Input register, combinational pose update and result register, with a
// bounded pose stack for the bracket commands.
// ----------------------------------------------------------------------------
// The block takes one symbol per clock while the result stream does not
// stall, and returns one result per symbol. The input register takes the
// symbol when it is accepted, and the result register is loaded from it
// when the input stage advances. The throughput of one symbol per cycle,
// when unstalled, is set by the pose update loop: moves, turns and stack
// pops all update the pose registers straight from the input register. A
// turn uses twelve multipliers of at most 16x17 bits, and a step uses three
// 17x16 multipliers. The stack lives in a memory with a registered top entry
// and a prefetched second entry, so pops are also served from registers;
// stack entries need no initialization after reset. Configuration writes are
// taken at any time but should only be issued while no symbol is in flight.
module lsystem_turtle_3d
  import lst3d_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write channel.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  // Symbol stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] symbol
  input  logic         s_axis_tuser,   // [0] restart
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,   // from_x, from_y, from_z, to_x, to_y, to_z
  output logic [2:0]   m_axis_tuser    // [0] drew, [2:1] status
);

  // Configuration registers.
  logic [15:0] step_q;
  q14_t        cos_q;
  q14_t        sin_q;
  coord_t      start_x_q;
  coord_t      start_y_q;

  // Pipeline control and payload.
  logic        in_valid_q;
  cmd_e        in_cmd_q;
  logic        out_valid_q;
  logic        advance;
  logic        in_accept;

  // Turtle pose.
  pos_t        pos_q;
  pos_t        pos_d;
  ori_t        ori_q;
  ori_t        ori_d;
  ori_t        ori_rot;
  pos_t        pos_moved;

  // Result fields.
  logic        drew_d;
  pos_t        from_d;
  pos_t        to_d;
  stat_e       status_d;
  logic        drew_q;
  pos_t        from_q;
  pos_t        to_q;
  stat_e       status_q;

  // Stack link.
  stk_ctrl_t   stk_ctrl;
  stk_stat_t   stk_stat;
  pose_t       stk_top;
  pose_t       stk_wr;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= 16'd25600;
      cos_q     <= 16'sd0;
      sin_q     <= 16'sd16384;
      start_x_q <= '0;
      start_y_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_STEP_LENGTH: step_q    <= cfg_data_i[15:0];
        REG_COS_TURN:    cos_q     <= cfg_data_i[15:0];
        REG_SIN_TURN:    sin_q     <= cfg_data_i[15:0];
        REG_START_X:     start_x_q <= cfg_data_i;
        REG_START_Y:     start_y_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Handshake: the input stage moves on whenever the result register is free or being taken.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Decode the symbol on the way into the input register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_cmd_q <= decode_symbol(s_axis_tdata, s_axis_tuser);
    end
  end

  // Turn and flip datapath.
  lst3d_rotate u_rotate (
    .cmd_i (in_cmd_q),
    .ori_i (ori_q),
    .cos_i (cos_q),
    .sin_i (sin_q),
    .ori_o (ori_rot)
  );

  // One step along the heading (first row of the orientation).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_moved[i] = step_coord(pos_q[i], step_q, ori_q[i]);
    end
  end

  // Next pose, stack request and result for the command in the input stage.
  always_comb begin
    pos_d    = pos_q;
    ori_d    = ori_q;
    stk_ctrl = '0;
    drew_d   = 1'b0;
    from_d   = '0;
    to_d     = '0;
    status_d = STAT_OK;
    if (advance) begin
      unique case (in_cmd_q)
        CMD_RESTART: begin
          pos_d[0]       = start_x_q;
          pos_d[1]       = start_y_q;
          pos_d[2]       = '0;
          ori_d          = ORI_IDENTITY;
          stk_ctrl.clear = 1'b1;
        end
        CMD_DRAW: begin
          pos_d  = pos_moved;
          drew_d = 1'b1;
          from_d = pos_q;
          to_d   = pos_moved;
        end
        CMD_MOVE: begin
          pos_d = pos_moved;
        end
        CMD_YAW_POS, CMD_YAW_NEG, CMD_PITCH_POS, CMD_PITCH_NEG,
        CMD_ROLL_POS, CMD_ROLL_NEG, CMD_FLIP: begin
          ori_d = ori_rot;
        end
        CMD_PUSH: begin
          if (stk_stat.full) begin
            status_d = STAT_FULL;
          end else begin
            stk_ctrl.push = 1'b1;
          end
        end
        CMD_POP: begin
          if (stk_stat.empty) begin
            status_d = STAT_EMPTY;
          end else begin
            stk_ctrl.pop = 1'b1;
            pos_d        = stk_top.pos;
            ori_d        = stk_top.ori;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ori_q <= ORI_IDENTITY;
    end else begin
      pos_q <= pos_d;
      ori_q <= ori_d;
    end
  end

  // Pose stack.
  assign stk_wr.pos = pos_q;
  assign stk_wr.ori = ori_q;

  lst3d_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (stk_ctrl),
    .pose_i (stk_wr),
    .top_o  (stk_top),
    .stat_o (stk_stat)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      drew_q   <= drew_d;
      from_q   <= from_d;
      to_q     <= to_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {to_q[2], to_q[1], to_q[0], from_q[2], from_q[1], from_q[0]};
  assign m_axis_tuser  = {status_q, drew_q};

endmodule
